>>> hdl/assert_macros.svh
// assertion macros used by the handle table datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold at every rising clock edge outside reset
`define HTM_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: assertion failed");

// consequent must hold in the same cycle as the antecedent
`define HTM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

`else

`define HTM_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define HTM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/htm_pkg.sv
// shared types and codes of the handle table map
package htm_pkg;

    typedef enum logic [1:0] {
        ACT_MARSHAL   = 2'd0,
        ACT_UNMARSHAL = 2'd1,
        ACT_DELETE    = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // how the datapath forms the pending result
    typedef enum logic [2:0] {
        RES_NONE,
        RES_NOT_FOUND,
        RES_DELETED,
        RES_HIT,
        RES_ALLOC,
        RES_FULL,
        RES_READ
    } t_res;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic scan_init;
        logic scan_step;
        logic rd_issue;
        logic wr_alloc;
        logic wr_del;
        t_res res;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic       cnt_last;
        logic [1:0] act;
        logic       ref_zero;
        logic       h_valid;
        logic       hit;
        logic       scan_end;
        logic       free_found;
        logic       out_free;
    } t_stat;

endpackage

>>> hdl/htm_dp.sv
// datapath: entry memory, scan counter, compare stage and output register
`include "assert_macros.svh"

module htm_dp #(
    parameter int ENTRIES   = 256,
    parameter int REF_WIDTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  htm_pkg::t_cmd        i_cmd,
    output htm_pkg::t_stat       o_stat,
    input  logic [1:0]           i_act,
    input  logic [REF_WIDTH-1:0] i_ref,
    input  logic [7:0]           i_hin,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [7:0]           o_out_handle,
    output logic [REF_WIDTH-1:0] o_out_obj,
    output logic [1:0]           o_out_status
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    logic [REF_WIDTH-1:0] r_mem [ENTRIES];
    logic [REF_WIDTH-1:0] r_rd_data;

    logic [1:0]           r_act;
    logic [REF_WIDTH-1:0] r_ref;
    logic [7:0]           r_hin;

    logic [IW-1:0] r_cnt;
    logic          r_issuing;
    logic          r_pend;
    logic [IW-1:0] r_pend_addr;
    logic          r_free_vld;
    logic [IW-1:0] r_free;
    logic [IW-1:0] r_last;

    logic [7:0]           r_res_handle;
    logic [REF_WIDTH-1:0] r_res_obj;
    logic [1:0]           r_res_status;

    logic                 r_out_vld;
    logic [7:0]           r_out_handle;
    logic [REF_WIDTH-1:0] r_out_obj;
    logic [1:0]           r_out_status;

    logic [IW-1:0]        w_h_idx;
    logic                 w_h_valid;
    logic                 w_hit;
    logic                 w_free_now;
    logic [IW-1:0]        w_alloc_addr;
    logic                 w_wr_en;
    logic [IW-1:0]        w_wr_addr;
    logic [REF_WIDTH-1:0] w_wr_data;
    logic                 w_rd_en;
    logic [IW-1:0]        w_rd_addr;
    logic                 w_out_free;

    function automatic logic [7:0] idx_to_handle(input logic [IW-1:0] idx);
        return 8'(32'(idx));
    endfunction

    assign w_h_valid = (r_hin != 8'd0) && (32'(r_hin) < 32'(ENTRIES));
    assign w_h_idx   = IW'(32'(r_hin));

    // compare stage sees the word read in the previous cycle
    assign w_hit      = r_pend && (r_rd_data == r_ref);
    assign w_free_now = r_pend && (r_rd_data == '0) && !r_free_vld && (r_pend_addr > r_last);
    assign w_alloc_addr = r_free_vld ? r_free : r_pend_addr;

    assign w_wr_en   = i_cmd.clr_step || i_cmd.wr_alloc || i_cmd.wr_del;
    assign w_wr_addr = i_cmd.clr_step ? r_cnt : (i_cmd.wr_alloc ? w_alloc_addr : w_h_idx);
    assign w_wr_data = i_cmd.wr_alloc ? r_ref : '0;

    assign w_rd_en   = i_cmd.rd_issue || (i_cmd.scan_step && r_issuing);
    assign w_rd_addr = i_cmd.rd_issue ? w_h_idx : r_cnt;

    assign w_out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_act;
            r_ref <= i_ref;
            r_hin <= i_hin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_issuing  <= 1'b0;
            r_pend     <= 1'b0;
            r_free_vld <= 1'b0;
            r_last     <= '0;
        end else begin
            r_pend <= i_cmd.scan_step && r_issuing;
            if (i_cmd.clr_step) begin
                r_cnt <= r_cnt + IW'(1);
            end else if (i_cmd.scan_init) begin
                // handle zero is reserved, scan starts at one
                r_cnt      <= IW'(1);
                r_issuing  <= 1'b1;
                r_free_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (r_issuing) begin
                    if (r_cnt == LAST_IDX) begin
                        r_issuing <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt + IW'(1);
                    end
                end
                if (w_free_now) begin
                    r_free_vld <= 1'b1;
                end
            end
            if (i_cmd.wr_alloc) begin
                r_last <= w_alloc_addr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_pend_addr <= r_cnt;
            if (w_free_now) begin
                r_free <= r_pend_addr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.res)
            htm_pkg::RES_NONE: begin
                r_res_handle <= r_res_handle;
            end
            htm_pkg::RES_DELETED: begin
                r_res_handle <= 8'd0;
                r_res_obj    <= '0;
                r_res_status <= htm_pkg::ST_OK;
            end
            htm_pkg::RES_HIT: begin
                r_res_handle <= idx_to_handle(r_pend_addr);
                r_res_obj    <= '0;
                r_res_status <= htm_pkg::ST_OK;
            end
            htm_pkg::RES_ALLOC: begin
                r_res_handle <= idx_to_handle(w_alloc_addr);
                r_res_obj    <= '0;
                r_res_status <= htm_pkg::ST_OK;
            end
            htm_pkg::RES_FULL: begin
                r_res_handle <= 8'd0;
                r_res_obj    <= '0;
                r_res_status <= htm_pkg::ST_FULL;
            end
            htm_pkg::RES_READ: begin
                r_res_handle <= 8'd0;
                r_res_obj    <= r_rd_data;
                r_res_status <= (r_rd_data != '0) ? htm_pkg::ST_OK : htm_pkg::ST_NOT_FOUND;
            end
            default: begin
                r_res_handle <= 8'd0;
                r_res_obj    <= '0;
                r_res_status <= htm_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // output register parts the result from the next item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_handle <= r_res_handle;
            r_out_obj    <= r_res_obj;
            r_out_status <= r_res_status;
        end
    end

    assign o_stat.cnt_last   = (r_cnt == LAST_IDX);
    assign o_stat.act        = r_act;
    assign o_stat.ref_zero   = (r_ref == '0);
    assign o_stat.h_valid    = w_h_valid;
    assign o_stat.hit        = w_hit;
    assign o_stat.scan_end   = r_pend && (r_pend_addr == LAST_IDX);
    assign o_stat.free_found = r_free_vld || w_free_now;
    assign o_stat.out_free   = w_out_free;

    assign o_out_valid  = r_out_vld;
    assign o_out_handle = r_out_handle;
    assign o_out_obj    = r_out_obj;
    assign o_out_status = r_out_status;

    `HTM_ASSERT_ALWAYS(a_hit_free_excl, i_clk, i_rst_n, !(w_hit && w_free_now))
    `HTM_ASSERT_IMPL(a_no_store_at_zero, i_clk, i_rst_n, w_wr_en && (w_wr_data != '0), w_wr_addr != '0)
    `HTM_ASSERT_IMPL(a_alloc_above_last, i_clk, i_rst_n, i_cmd.wr_alloc, w_alloc_addr > r_last)
    `HTM_ASSERT_IMPL(a_no_result_overrun, i_clk, i_rst_n, i_cmd.out_load, w_out_free)

endmodule

>>> hdl/htm_ctrl.sv
// controller state machine of the handle table map
module htm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  htm_pkg::t_stat i_stat,
    output htm_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_READ,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res = htm_pkg::RES_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (i_stat.act)
                    htm_pkg::ACT_MARSHAL: begin
                        if (i_stat.ref_zero) begin
                            o_cmd.res = htm_pkg::RES_NOT_FOUND;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end
                    end
                    htm_pkg::ACT_UNMARSHAL: begin
                        if (i_stat.h_valid) begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_READ;
                        end else begin
                            o_cmd.res = htm_pkg::RES_NOT_FOUND;
                        end
                    end
                    htm_pkg::ACT_DELETE: begin
                        if (i_stat.h_valid) begin
                            o_cmd.wr_del = 1'b1;
                            o_cmd.res    = htm_pkg::RES_DELETED;
                        end else begin
                            o_cmd.res = htm_pkg::RES_NOT_FOUND;
                        end
                    end
                    default: begin
                        o_cmd.res = htm_pkg::RES_NOT_FOUND;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.hit) begin
                    o_cmd.res = htm_pkg::RES_HIT;
                    n_state   = S_DONE;
                end else if (i_stat.scan_end) begin
                    // no match anywhere: take the first free slot above the last handle
                    if (i_stat.free_found) begin
                        o_cmd.wr_alloc = 1'b1;
                        o_cmd.res      = htm_pkg::RES_ALLOC;
                    end else begin
                        o_cmd.res = htm_pkg::RES_FULL;
                    end
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                o_cmd.res = htm_pkg::RES_READ;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

>>> hdl/handle_table_map_top.sv
// top level of the handle table map
//
// a table of ENTRIES object references reached by small handles, with
// handle zero reserved and an entry of zero meaning empty.
// input channel s_axis: tuser carries the action (marshal, unmarshal,
// delete), tdata the object reference and the handle. output channel
// m_axis: tdata carries the handle and the object, tuser the status.
// one item is worked on at a time and gives exactly one result.
// marshal reads the entries in one pass through the single read port of
// the entry memory, one memory read per entry, and finds match and free
// slot in the same pass; a match ends the pass early. unmarshal reads its
// one entry; delete and rejected items do not read. the next item is
// taken once the result has entered the output register.
// after reset the block clears every entry of the memory, one entry per
// cycle, with tready low; last handle resets to zero.
// a stalled receiver holds the result in the output register; the next
// item is still accepted and its result waits until the register frees.
module handle_table_map_top #(
    parameter int ENTRIES   = 256,
    parameter int REF_WIDTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // object_ref, handle_in
    input  logic [71:0]          s_axis_tdata,
    // action
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // handle_out, object_out
    output logic [71:0]          m_axis_tdata,
    // status
    output logic [1:0]           m_axis_tuser
);

    htm_pkg::t_cmd  w_cmd;
    htm_pkg::t_stat w_stat;

    logic [7:0]           w_out_handle;
    logic [REF_WIDTH-1:0] w_out_obj;

    htm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    htm_dp #(
        .ENTRIES   (ENTRIES),
        .REF_WIDTH (REF_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_act        (s_axis_tuser),
        .i_ref        (s_axis_tdata[REF_WIDTH-1:0]),
        .i_hin        (s_axis_tdata[71:64]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_handle (w_out_handle),
        .o_out_obj    (w_out_obj),
        .o_out_status (m_axis_tuser)
    );

    assign m_axis_tdata = {64'(w_out_obj), w_out_handle};

endmodule

>>> verif/handle_table_map_top_tb.sv
// testbench for the handle table map: directed and random traffic checked against a model
`timescale 1ns / 100ps

module handle_table_map_top_tb;

    localparam int ENTRIES = 256;
    localparam int REF_WIDTH = 64;
    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 378;
    localparam int LONG_HOLD = 1500;

    typedef struct {
        logic [7:0]       handle;
        logic [63:0]      obj;
        htm_pkg::t_status st;
    } t_lookup_result;

    class handle_table_scoreboard;
        logic [63:0]    refs [ENTRIES];
        int unsigned    last_alloc;
        t_lookup_result pending_q[$];
        int unsigned    errors, n_checked, n_alloc, n_hit, n_full;
        int unsigned    n_read, n_del, n_reject;

        function new();
            for (int i = 0; i < ENTRIES; i++) refs[i] = '0;
            last_alloc = 0;
            errors = 0;
            n_checked = 0;
            n_alloc = 0;
            n_hit = 0;
            n_full = 0;
            n_read = 0;
            n_del = 0;
            n_reject = 0;
        endfunction

        function void note_input(logic [1:0] act, logic [63:0] obj, logic [7:0] h);
            t_lookup_result e;
            bit             done;
            e.handle = '0;
            e.obj = '0;
            e.st = htm_pkg::ST_NOT_FOUND;
            done = 0;
            case (act)
                htm_pkg::ACT_MARSHAL: begin
                    if (obj != '0) begin
                        // search every entry first, then scan upward for a free one
                        for (int i = 1; i < ENTRIES; i++) begin
                            if (!done && refs[i] == obj) begin
                                e.handle = 8'(i);
                                e.st = htm_pkg::ST_OK;
                                done = 1;
                                n_hit++;
                            end
                        end
                        for (int i = last_alloc + 1; i < ENTRIES; i++) begin
                            if (!done && refs[i] == '0) begin
                                refs[i] = obj;
                                last_alloc = i;
                                e.handle = 8'(i);
                                e.st = htm_pkg::ST_OK;
                                done = 1;
                                n_alloc++;
                            end
                        end
                        if (!done) begin
                            e.st = htm_pkg::ST_FULL;
                            n_full++;
                        end
                    end else begin
                        n_reject++;
                    end
                end
                htm_pkg::ACT_UNMARSHAL: begin
                    if (h != 0 && h < ENTRIES && refs[h] != '0) begin
                        e.obj = refs[h];
                        e.st = htm_pkg::ST_OK;
                        n_read++;
                    end else begin
                        n_reject++;
                    end
                end
                htm_pkg::ACT_DELETE: begin
                    if (h != 0 && h < ENTRIES) begin
                        refs[h] = '0;
                        e.st = htm_pkg::ST_OK;
                        n_del++;
                    end else begin
                        n_reject++;
                    end
                end
                default: n_reject++;
            endcase
            pending_q.push_back(e);
        endfunction

        function void check_result(logic [7:0] hd, logic [63:0] obj, logic [1:0] st);
            t_lookup_result e;
            n_checked++;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: handle %0d object %h status %0d",
                             hd, obj, st);
            end else begin
                e = pending_q.pop_front();
                if (hd !== e.handle || obj !== e.obj || st !== e.st) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("mismatch on result %0d: handle exp %0d got %0d,",
                                 n_checked, e.handle, hd);
                        $display("    object exp %h got %h, status exp %0d got %0d",
                                 e.obj, obj, e.st, st);
                    end
                end
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    // object_ref, handle_in
    logic [71:0]   s_axis_tdata = '0;
    // action
    logic [1:0]    s_axis_tuser = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    // handle_out, object_out
    logic [71:0]   m_axis_tdata;
    // status
    logic [1:0]    m_axis_tuser;

    int unsigned   tx_idle_pct = 6;
    int unsigned   rx_idle_pct = 53;
    int unsigned   hold_left = 0;
    int unsigned   n_sent = 0;
    logic [63:0]   known_refs[$];

    handle_table_scoreboard sb = new();

    handle_table_map_top #(
        .ENTRIES   (ENTRIES),
        .REF_WIDTH (REF_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("handle_table_map_top_tb: done, errors");
        $finish;
    end

    // result side: check each transfer, then pick the next tready
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[7:0], m_axis_tdata[71:8], m_axis_tuser);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // valid stays high from one item to the next unless a gap is drawn
    task automatic send_item(input logic [1:0] act, input logic [63:0] obj,
                             input logic [7:0] h);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 72'({$urandom, $urandom, $urandom});
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {h, obj};
        s_axis_tuser <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(act, obj, h);
        n_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_item();
        int unsigned pick;
        logic [1:0]  act;
        logic [63:0] obj;
        logic [7:0]  h;
        pick = $urandom_range(99);
        obj = {$urandom, $urandom};
        // half the handles aim at the range given out so far
        h = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(sb.last_alloc));
        if (pick < 35) begin
            act = htm_pkg::ACT_MARSHAL;
        end else if (pick < 50) begin
            act = htm_pkg::ACT_MARSHAL;
            if (known_refs.size() != 0)
                obj = known_refs[$urandom_range(known_refs.size() - 1)];
        end else if (pick < 52) begin
            act = htm_pkg::ACT_MARSHAL;
            obj = '0;
        end else if (pick < 77) begin
            act = htm_pkg::ACT_UNMARSHAL;
        end else if (pick < 97) begin
            act = htm_pkg::ACT_DELETE;
        end else begin
            act = ACT_RESERVED;
        end
        if (act == htm_pkg::ACT_MARSHAL && obj != '0) known_refs.push_back(obj);
        send_item(act, obj, h);
    endtask

    initial begin
        int ph;
        int n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, zero reference, repeats, bad handles, reserved action
        send_item(htm_pkg::ACT_UNMARSHAL, 64'h0, 8'd1);
        send_item(htm_pkg::ACT_MARSHAL, 64'h0, 8'hFF);
        send_item(htm_pkg::ACT_MARSHAL, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
        send_item(htm_pkg::ACT_MARSHAL, 64'h1, 8'd0);
        send_item(htm_pkg::ACT_MARSHAL, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
        send_item(htm_pkg::ACT_UNMARSHAL, 64'hFFFF_FFFF_FFFF_FFFF, 8'd1);
        send_item(htm_pkg::ACT_UNMARSHAL, 64'h0, 8'd0);
        send_item(htm_pkg::ACT_UNMARSHAL, 64'h0, 8'hFF);
        send_item(htm_pkg::ACT_DELETE, 64'h0, 8'd0);
        send_item(htm_pkg::ACT_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
        send_item(htm_pkg::ACT_DELETE, 64'h0, 8'd2);
        send_item(htm_pkg::ACT_UNMARSHAL, 64'h0, 8'd2);
        // freed slot at the last handle is not reused
        send_item(htm_pkg::ACT_MARSHAL, 64'h1, 8'd0);
        send_item(ACT_RESERVED, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
        send_item(htm_pkg::ACT_MARSHAL, 64'h8000_0000_0000_0000, 8'd0);
        send_item(htm_pkg::ACT_MARSHAL, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55);
        send_item(htm_pkg::ACT_MARSHAL, 64'h5555_5555_5555_5555, 8'hAA);
        send_item(htm_pkg::ACT_UNMARSHAL, 64'h0, 8'd3);
        known_refs.push_back(64'h1);
        known_refs.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        drain();

        for (ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 53 : 0;
            rx_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 6 : 0;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver stall while items keep coming
                if (ph == 0 && n == 120) hold_left = LONG_HOLD;
                random_item();
            end
            drain();
        end

        repeat (ENTRIES + 10) @(posedge i_clk);
        $display("sent %0d items, checked %0d results: %0d allocations, %0d repeat hits, %0d full",
                 n_sent, sb.n_checked, sb.n_alloc, sb.n_hit, sb.n_full);
        $display("lookups %0d, deletes %0d, rejected or not found %0d, errors %0d",
                 sb.n_read, sb.n_del, sb.n_reject, sb.errors);
        if (sb.errors == 0)
            $display("handle_table_map_top_tb: done, clean");
        else
            $display("handle_table_map_top_tb: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/htm_pkg.sv
hdl/htm_dp.sv
hdl/htm_ctrl.sv
hdl/handle_table_map_top.sv
verif/handle_table_map_top_tb.sv
